>>> src/tlca_pkg.sv
// Shared types and constants for the tree lowest-common-ancestor block.
// Used by tree_lca_binary_lifting and its checker; no dependencies.
`default_nettype none
package tlca_pkg;
  localparam int NODE_W      = 10;
  localparam int MAX_NODES   = 1 << NODE_W;
  localparam int LIFT_LEVELS = 10;
  localparam int LVL_W       = 4;
  localparam int ADJ_W       = 11;
  localparam int MAX_ADJ     = 1 << ADJ_W;
  localparam int CNT_W       = ADJ_W + 1;
  localparam int ANC_AW      = LVL_W + NODE_W;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NO_BUILD = 2'd3
  } status_t;

  typedef enum logic {
    REG_NODE_COUNT = 1'b0,
    REG_ROOT_NODE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t              command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    status_t           status;
  } out_res_t;
endpackage
`default_nettype wire

>>> src/tree_lca_binary_lifting.sv
// Tree LCA by binary lifting: adjacency store, BFS build, lifting queries.
// Depends on tlca_pkg.
`default_nettype none
// Usage:
//   Requests enter on in_req when start is high and busy is low. Each request
//   gives exactly one result on out_res, marked by out_valid for one cycle;
//   the receiver cannot stall, so it must take it then.
//   cfg_we writes node_count (index 0) or root_node (index 1); the user must
//   write them only while idle, as the block itself has no check for that.
//   add and clear: result the cycle after the request, block stays ready.
//   query: reads both depths, lifts the deeper node by each set bit of the
//     depth difference (at most LIFT_LEVELS) and answers if it then meets the
//     other node, else climbs both from the top level down and answers with
//     the level-0 ancestor of x; each step is one ancestor memory read.
//   build: a clearing pass over reached/depth/level 0 for every node, a step
//     to seed the queue with the root, for each queued node a pop and a scan
//     of every stored adjacency entry, then for each node and upper level one
//     or two reads of the level below and a write, the result the cycle after.
//   busy stays high until the result is shown; a new request may be taken in
//   the same cycle that the result is on the ports.
// Reset: clears the adjacency count, the built flag and the sequencer, and
//   sets node_count and root_node to 1; the memories hold garbage until
//   written, and their contents are never used before that.
module tree_lca_binary_lifting (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire tlca_pkg::in_req_t     in_req,
  output logic                       out_valid,
  output tlca_pkg::out_res_t         out_res,
  input  wire                        cfg_we,
  input  wire                        cfg_addr,
  input  wire [tlca_pkg::NODE_W-1:0] cfg_data
);
  localparam int NW = tlca_pkg::NODE_W;
  localparam int LW = tlca_pkg::LVL_W;

  typedef enum logic [20:0] {
    S_IDLE      = 21'd1 << 0,
    S_SWEEP     = 21'd1 << 1,
    S_BFS_INIT  = 21'd1 << 2,
    S_BFS_DEQ   = 21'd1 << 3,
    S_BFS_POP   = 21'd1 << 4,
    S_EDGE_RD   = 21'd1 << 5,
    S_EDGE_CHK  = 21'd1 << 6,
    S_EDGE_UPD  = 21'd1 << 7,
    S_LVL_RD    = 21'd1 << 8,
    S_LVL_PAR   = 21'd1 << 9,
    S_LVL_WR    = 21'd1 << 10,
    S_Q_DA      = 21'd1 << 11,
    S_Q_DB      = 21'd1 << 12,
    S_Q_ALIGN   = 21'd1 << 13,
    S_LIFT_RD   = 21'd1 << 14,
    S_LIFT_WR   = 21'd1 << 15,
    S_LIFT_END  = 21'd1 << 16,
    S_CLIMB_X   = 21'd1 << 17,
    S_CLIMB_Y   = 21'd1 << 18,
    S_CLIMB_CMP = 21'd1 << 19,
    S_Q_FINAL   = 21'd1 << 20
  } state_t;

  // S_Q_DONE folded: result taken from read data in the state after S_Q_FINAL
  state_t state_r, state_nxt;
  logic   final_r, final_nxt;

  logic [NW-1:0]              node_count_r, root_node_r;
  logic [tlca_pkg::CNT_W-1:0] adj_count_r, adj_count_nxt;
  logic                       built_r, built_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tlca_pkg::out_res_t         out_res_r, out_res_nxt;

  logic [NW-1:0]              x_r, x_nxt, y_r, y_nxt, dx_r, dx_nxt;
  logic [NW-1:0]              diff_r, diff_nxt, ax_r, ax_nxt;
  logic [LW-1:0]              lvl_r, lvl_nxt;
  logic [NW-1:0]              idx_r, idx_nxt;
  logic [NW:0]                head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0]              u_r, u_nxt, du_r, du_nxt, v_r, v_nxt;
  logic [tlca_pkg::CNT_W-1:0] e_r, e_nxt;

  // memories
  logic [2*NW-1:0] adj_mem [tlca_pkg::MAX_ADJ];
  logic            reach_mem [tlca_pkg::MAX_NODES];
  logic [NW-1:0]   dep_mem [tlca_pkg::MAX_NODES];
  logic [NW-1:0]   anc_mem [tlca_pkg::LIFT_LEVELS*tlca_pkg::MAX_NODES];
  logic [2*NW-1:0] q_mem [tlca_pkg::MAX_NODES];

  logic                       adj_we;
  logic [tlca_pkg::ADJ_W-1:0] adj_waddr, adj_raddr;
  logic [2*NW-1:0]            adj_wdata, adj_rdata;
  logic                       reach_we, reach_wdata, reach_rdata;
  logic [NW-1:0]              reach_waddr, reach_raddr;
  logic                       dep_we;
  logic [NW-1:0]              dep_waddr, dep_wdata, dep_raddr, dep_rdata;
  logic                       anc_we;
  logic [tlca_pkg::ANC_AW-1:0] anc_waddr, anc_raddr;
  logic [NW-1:0]              anc_wdata, anc_rdata;
  logic                       q_we;
  logic [NW-1:0]              q_waddr, q_raddr;
  logic [2*NW-1:0]            q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata <= adj_mem[adj_raddr];
  end
  always_ff @(posedge clk) begin
    if (reach_we) reach_mem[reach_waddr] <= reach_wdata;
    reach_rdata <= reach_mem[reach_raddr];
  end
  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    dep_rdata <= dep_mem[dep_raddr];
  end
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    anc_rdata <= anc_mem[anc_raddr];
  end
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[q_raddr];
  end

  function automatic logic node_ok(input logic [NW-1:0] n, input logic [NW-1:0] cnt);
    node_ok = (n != '0) && (n <= cnt);
  endfunction

  logic [NW-1:0] ay, dy, adj_src, adj_tgt;
  assign ay = anc_rdata;
  assign dy = dep_rdata;
  assign adj_src = adj_rdata[2*NW-1:NW];
  assign adj_tgt = adj_rdata[NW-1:0];

  always_comb begin
    state_nxt     = state_r;
    final_nxt     = 1'b0;
    adj_count_nxt = adj_count_r;
    built_nxt     = built_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    x_nxt = x_r; y_nxt = y_r; dx_nxt = dx_r; diff_nxt = diff_r; ax_nxt = ax_r;
    lvl_nxt = lvl_r; idx_nxt = idx_r; head_nxt = head_r; tail_nxt = tail_r;
    u_nxt = u_r; du_nxt = du_r; v_nxt = v_r; e_nxt = e_r;

    adj_we = 1'b0;
    adj_waddr = adj_count_r[tlca_pkg::ADJ_W-1:0];
    adj_wdata = {in_req.node_a, in_req.node_b};
    adj_raddr = e_r[tlca_pkg::ADJ_W-1:0];
    reach_we = 1'b0; reach_waddr = idx_r; reach_wdata = 1'b0; reach_raddr = adj_tgt;
    dep_we = 1'b0; dep_waddr = idx_r; dep_wdata = '0; dep_raddr = x_r;
    anc_we = 1'b0; anc_waddr = {LW'(0), idx_r}; anc_wdata = '0; anc_raddr = {lvl_r, x_r};
    q_we = 1'b0; q_waddr = tail_r[NW-1:0]; q_wdata = '0; q_raddr = head_r[NW-1:0];

    if (final_r) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{ancestor: anc_rdata, status: tlca_pkg::ST_OK};
    end

    unique case (state_r)
      S_IDLE: begin
        if (start && !final_r) begin
          out_res_nxt = '{ancestor: '0, status: tlca_pkg::ST_OK};
          unique case (in_req.command)
            tlca_pkg::CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (!node_ok(in_req.node_a, node_count_r) ||
                  !node_ok(in_req.node_b, node_count_r)) begin
                out_res_nxt.status = tlca_pkg::ST_RANGE;
              end else if (adj_count_r == tlca_pkg::CNT_W'(tlca_pkg::MAX_ADJ)) begin
                out_res_nxt.status = tlca_pkg::ST_FULL;
              end else begin
                adj_we        = 1'b1;
                adj_count_nxt = adj_count_r + 1'b1;
              end
            end
            tlca_pkg::CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              adj_count_nxt = '0;
              built_nxt     = 1'b0;
            end
            tlca_pkg::CMD_BUILD: begin
              built_nxt = 1'b0;
              if (!node_ok(root_node_r, node_count_r)) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = tlca_pkg::ST_RANGE;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SWEEP;
              end
            end
            tlca_pkg::CMD_QUERY: begin
              if (!built_r) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = tlca_pkg::ST_NO_BUILD;
              end else if (!node_ok(in_req.node_a, node_count_r) ||
                           !node_ok(in_req.node_b, node_count_r)) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = tlca_pkg::ST_RANGE;
              end else begin
                x_nxt     = in_req.node_a;
                y_nxt     = in_req.node_b;
                state_nxt = S_Q_DA;
              end
            end
            default: ;
          endcase
        end
      end
      // clear reached, depth and level-0 ancestor for every node
      S_SWEEP: begin
        reach_we = 1'b1;
        dep_we   = 1'b1;
        anc_we   = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == '1) state_nxt = S_BFS_INIT;
      end
      S_BFS_INIT: begin
        reach_we    = 1'b1;
        reach_waddr = root_node_r;
        reach_wdata = 1'b1;
        q_we        = 1'b1;
        q_waddr     = '0;
        q_wdata     = {root_node_r, NW'(0)};
        head_nxt    = '0;
        tail_nxt    = (NW+1)'(1);
        state_nxt   = S_BFS_DEQ;
      end
      S_BFS_DEQ: begin
        if (head_r == tail_r) begin
          lvl_nxt   = LW'(1);
          idx_nxt   = NW'(1);
          state_nxt = S_LVL_RD;
        end else begin
          state_nxt = S_BFS_POP;
        end
      end
      S_BFS_POP: begin
        u_nxt     = q_rdata[2*NW-1:NW];
        du_nxt    = q_rdata[NW-1:0];
        head_nxt  = head_r + 1'b1;
        e_nxt     = '0;
        state_nxt = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        if (e_r == adj_count_r) state_nxt = S_BFS_DEQ;
        else state_nxt = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        v_nxt = adj_tgt;
        if (adj_src == u_r && node_ok(adj_tgt, node_count_r)) begin
          state_nxt = S_EDGE_UPD;
        end else begin
          e_nxt     = e_r + 1'b1;
          state_nxt = S_EDGE_RD;
        end
      end
      S_EDGE_UPD: begin
        if (!reach_rdata) begin
          reach_we    = 1'b1;
          reach_waddr = v_r;
          reach_wdata = 1'b1;
          dep_we      = 1'b1;
          dep_waddr   = v_r;
          dep_wdata   = du_r + 1'b1;
          anc_we      = 1'b1;
          anc_waddr   = {LW'(0), v_r};
          anc_wdata   = u_r;
          q_we        = 1'b1;
          q_wdata     = {v_r, du_r + NW'(1)};
          tail_nxt    = tail_r + 1'b1;
        end
        e_nxt     = e_r + 1'b1;
        state_nxt = S_EDGE_RD;
      end
      // upper levels: anc[j][i] = anc[j-1][anc[j-1][i]], node 0 has none
      S_LVL_RD: begin
        anc_raddr = {lvl_r - 1'b1, idx_r};
        state_nxt = S_LVL_PAR;
      end
      S_LVL_PAR, S_LVL_WR: begin
        anc_raddr = {lvl_r - 1'b1, anc_rdata};
        if (state_r == S_LVL_PAR && anc_rdata != '0) begin
          state_nxt = S_LVL_WR;
        end else begin
          anc_we    = 1'b1;
          anc_waddr = {lvl_r, idx_r};
          anc_wdata = (state_r == S_LVL_WR) ? anc_rdata : '0;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LVL_RD;
          if (idx_r == '1) begin
            idx_nxt = NW'(1);
            lvl_nxt = lvl_r + 1'b1;
            if (lvl_r == LW'(tlca_pkg::LIFT_LEVELS - 1)) begin
              built_nxt     = 1'b1;
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{ancestor: '0, status: tlca_pkg::ST_OK};
              state_nxt     = S_IDLE;
            end
          end
        end
      end
      S_Q_DA: begin
        dep_raddr = x_r;
        state_nxt = S_Q_DB;
      end
      S_Q_DB: begin
        dx_nxt    = dep_rdata;
        dep_raddr = y_r;
        state_nxt = S_Q_ALIGN;
      end
      S_Q_ALIGN: begin
        if (dx_r < dy) begin
          x_nxt    = y_r;
          y_nxt    = x_r;
          diff_nxt = dy - dx_r;
        end else begin
          diff_nxt = dx_r - dy;
        end
        lvl_nxt   = LW'(tlca_pkg::LIFT_LEVELS - 1);
        state_nxt = S_LIFT_RD;
      end
      S_LIFT_RD: begin
        if (diff_r[lvl_r]) state_nxt = S_LIFT_WR;
        else if (lvl_r == '0) state_nxt = S_LIFT_END;
        else lvl_nxt = lvl_r - 1'b1;
      end
      S_LIFT_WR: begin
        x_nxt = anc_rdata;
        if (lvl_r == '0) begin
          state_nxt = S_LIFT_END;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_LIFT_RD;
        end
      end
      S_LIFT_END: begin
        if (x_r == y_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{ancestor: x_r, status: tlca_pkg::ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          lvl_nxt   = LW'(tlca_pkg::LIFT_LEVELS - 1);
          state_nxt = S_CLIMB_X;
        end
      end
      S_CLIMB_X: begin
        state_nxt = S_CLIMB_Y;
      end
      S_CLIMB_Y: begin
        ax_nxt    = anc_rdata;
        anc_raddr = {lvl_r, y_r};
        state_nxt = S_CLIMB_CMP;
      end
      S_CLIMB_CMP: begin
        if (ax_r != '0 && ax_r != ay) begin
          x_nxt = ax_r;
          y_nxt = ay;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_FINAL;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_CLIMB_X;
        end
      end
      S_Q_FINAL: begin
        anc_raddr = {LW'(0), x_r};
        final_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      final_r      <= 1'b0;
      node_count_r <= NW'(1);
      root_node_r  <= NW'(1);
      adj_count_r  <= '0;
      built_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      final_r     <= final_nxt;
      adj_count_r <= adj_count_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_addr == tlca_pkg::REG_NODE_COUNT) node_count_r <= cfg_data;
        else root_node_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    x_r <= x_nxt; y_r <= y_nxt; dx_r <= dx_nxt; diff_r <= diff_nxt; ax_r <= ax_nxt;
    lvl_r <= lvl_nxt; idx_r <= idx_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
    u_r <= u_nxt; du_r <= du_nxt; v_r <= v_nxt; e_r <= e_nxt;
  end

  // final_r keeps busy high while the last ancestor read is in flight
  assign busy      = (state_r != S_IDLE) || final_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
endmodule
`default_nettype wire

>>> src/tlca_checker.sv
// Port-level checker for tree_lca_binary_lifting, bound into each instance of it.
// Depends on tlca_pkg.
`default_nettype none
module tlca_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     start,
  input wire                     busy,
  input wire                     out_valid,
  input wire tlca_pkg::out_res_t out_res
);
  // every accepted request is either answered next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  // busy only drops together with a result
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || out_valid))
    else $error("busy dropped without a result");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_error_no_ancestor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != tlca_pkg::ST_OK) |-> (out_res.ancestor == '0))
    else $error("error result carries an ancestor");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity right after reset");
endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
`default_nettype wire

>>> tb/tlca_checker.sv
// Checker for tree_lca_binary_lifting: watches request, result and config ports,
// predicts each result and compares it. Depends on tlca_pkg.
`timescale 1ns / 1ps
module tlca_scoreboard (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire                         busy,
  input  tlca_pkg::in_req_t           in_req,
  input  wire                         out_valid,
  input  tlca_pkg::out_res_t          out_res,
  input  wire                         cfg_we,
  input  wire                         cfg_addr,
  input  wire [tlca_pkg::NODE_W-1:0]  cfg_data,
  output int                          pending,
  output int                          errors
);
  localparam int NW = tlca_pkg::NODE_W;

  logic [NW-1:0]      node_count, root_node;
  logic [NW-1:0]      edge_src [tlca_pkg::MAX_ADJ];
  logic [NW-1:0]      edge_dst [tlca_pkg::MAX_ADJ];
  int                 edge_cnt;
  bit                 built;
  int                 depth [tlca_pkg::MAX_NODES];
  logic [NW-1:0]      lift [tlca_pkg::MAX_NODES][tlca_pkg::LIFT_LEVELS];
  tlca_pkg::out_res_t lca_due [$];

  function automatic bit valid_node(logic [NW-1:0] n);
    return n >= 1 && n <= node_count;
  endfunction

  // BFS from the root; first visit fixes the parent.
  function automatic void build_lift();
    bit            seen [tlca_pkg::MAX_NODES];
    logic [NW-1:0] fifo [$];
    logic [NW-1:0] u, v, p;
    for (int i = 0; i < tlca_pkg::MAX_NODES; i++) begin
      seen[i] = 0;
      depth[i] = 0;
      for (int k = 0; k < tlca_pkg::LIFT_LEVELS; k++) lift[i][k] = '0;
    end
    seen[root_node] = 1;
    fifo.push_back(root_node);
    while (fifo.size() > 0) begin
      u = fifo.pop_front();
      for (int e = 0; e < edge_cnt; e++) begin
        v = edge_dst[e];
        if (edge_src[e] != u || !valid_node(v) || seen[v]) continue;
        seen[v] = 1;
        depth[v] = depth[u] + 1;
        lift[v][0] = u;
        fifo.push_back(v);
      end
    end
    for (int k = 1; k < tlca_pkg::LIFT_LEVELS; k++)
      for (int i = 1; i < tlca_pkg::MAX_NODES; i++) begin
        p = lift[i][k-1];
        lift[i][k] = lift[p][k-1];
      end
    built = 1;
  endfunction

  function automatic logic [NW-1:0] common_anc(logic [NW-1:0] x0, logic [NW-1:0] y0);
    logic [NW-1:0] x, y, t, ax, ay;
    int            gap;
    x = x0;
    y = y0;
    if (depth[x] < depth[y]) begin
      t = x; x = y; y = t;
    end
    gap = depth[x] - depth[y];
    for (int k = tlca_pkg::LIFT_LEVELS - 1; k >= 0; k--)
      if (gap >= (1 << k)) begin
        gap -= (1 << k);
        x = lift[x][k];
      end
    if (x == y) return x;
    for (int k = tlca_pkg::LIFT_LEVELS - 1; k >= 0; k--) begin
      ax = lift[x][k];
      ay = lift[y][k];
      if (ax != 0 && ax != ay) begin
        x = ax;
        y = ay;
      end
    end
    return lift[x][0];
  endfunction

  function automatic tlca_pkg::out_res_t apply_request(tlca_pkg::in_req_t r);
    tlca_pkg::out_res_t res;
    res.ancestor = '0;
    res.status = tlca_pkg::ST_OK;
    case (r.command)
      tlca_pkg::CMD_ADD: begin
        if (!valid_node(r.node_a) || !valid_node(r.node_b)) res.status = tlca_pkg::ST_RANGE;
        else if (edge_cnt >= tlca_pkg::MAX_ADJ) res.status = tlca_pkg::ST_FULL;
        else begin
          edge_src[edge_cnt] = r.node_a;
          edge_dst[edge_cnt] = r.node_b;
          edge_cnt++;
        end
      end
      tlca_pkg::CMD_CLEAR: begin
        edge_cnt = 0;
        built = 0;
      end
      tlca_pkg::CMD_BUILD: begin
        if (!valid_node(root_node)) begin
          res.status = tlca_pkg::ST_RANGE;
          built = 0;
        end else build_lift();
      end
      default: begin
        if (!built) res.status = tlca_pkg::ST_NO_BUILD;
        else if (!valid_node(r.node_a) || !valid_node(r.node_b))
          res.status = tlca_pkg::ST_RANGE;
        else res.ancestor = common_anc(r.node_a, r.node_b);
      end
    endcase
    return res;
  endfunction

  assign pending = lca_due.size();

  initial errors = 0;

  always @(posedge clk) begin
    tlca_pkg::out_res_t want;
    if (!rst_n) begin
      node_count <= NW'(1);
      root_node <= NW'(1);
      edge_cnt = 0;
      built = 0;
      lca_due.delete();
    end else begin
      if (out_valid) begin
        if (lca_due.size() == 0) begin
          $error("result with no request outstanding: ancestor %0d status %0d",
                 out_res.ancestor, out_res.status);
          errors++;
        end else begin
          want = lca_due.pop_front();
          if (out_res.ancestor !== want.ancestor) begin
            $error("ancestor: expected %0d, got %0d", want.ancestor, out_res.ancestor);
            errors++;
          end
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            errors++;
          end
        end
      end
      if (start && !busy) lca_due.push_back(apply_request(in_req));
      if (cfg_we) begin
        if (cfg_addr == tlca_pkg::REG_NODE_COUNT) node_count <= cfg_data;
        else root_node <= cfg_data;
      end
    end
  end
endmodule

>>> tb/testbench.sv
// Top of the tree_lca_binary_lifting testbench: clock, reset, stimulus, verdict.
// Depends on tlca_pkg, tree_lca_binary_lifting and tlca_scoreboard.
`timescale 1ns / 1ps
module testbench;
  localparam int NW = tlca_pkg::NODE_W;
  localparam int STALL_LIMIT = 300000;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                start = 0;
  logic                busy;
  tlca_pkg::in_req_t   in_req = '0;
  logic                out_valid;
  tlca_pkg::out_res_t  out_res;
  logic                cfg_we = 0;
  logic                cfg_addr = 0;
  logic [NW-1:0]       cfg_data = '0;
  int                  pending, errors;
  int                  idle_pct = 0;
  int                  quiet_cycles = 0;

  tree_lca_binary_lifting u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  tlca_scoreboard u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic issue(input tlca_pkg::cmd_t c, input logic [NW-1:0] a,
                       input logic [NW-1:0] b);
    tlca_pkg::in_req_t r;
    r.command = c;
    r.node_a = a;
    r.node_b = b;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drain outstanding requests, then write both registers
  task automatic set_regs(input logic [NW-1:0] nc, input logic [NW-1:0] root);
    @(negedge clk);
    start <= 0;
    wait (pending == 0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= tlca_pkg::REG_NODE_COUNT;
    cfg_data <= nc;
    @(negedge clk);
    cfg_addr <= tlca_pkg::REG_ROOT_NODE;
    cfg_data <= root;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(input int p);
    logic [NW-1:0] lbl [64];
    bit            used [tlca_pkg::MAX_NODES];
    int            nc, sz, cap, par;
    logic [NW-1:0] a, b, root;
    nc = (p == 0) ? 1023 : $urandom_range(2, 80);
    cap = (nc < 25) ? nc : 25;
    sz = $urandom_range(2, cap);
    foreach (used[i]) used[i] = 0;
    for (int i = 0; i < sz; i++) begin
      do a = NW'($urandom_range(1, nc)); while (used[a]);
      used[a] = 1;
      lbl[i] = a;
    end
    root = (p == 3) ? NW'(nc + 1) : lbl[0];   // phase 3 builds from a bad root
    idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 59 : 31;
    set_regs(NW'(nc), root);
    issue(tlca_pkg::CMD_CLEAR, NW'($urandom), NW'($urandom));
    for (int i = 1; i < sz; i++) begin
      par = $urandom_range(0, i - 1);
      if ($urandom_range(1) == 1) begin
        issue(tlca_pkg::CMD_ADD, lbl[par], lbl[i]);
        issue(tlca_pkg::CMD_ADD, lbl[i], lbl[par]);
      end else begin
        issue(tlca_pkg::CMD_ADD, lbl[i], lbl[par]);
        issue(tlca_pkg::CMD_ADD, lbl[par], lbl[i]);
      end
      if ($urandom_range(9) == 0) issue(tlca_pkg::CMD_ADD, NW'($urandom), NW'($urandom));
      if ($urandom_range(14) == 0)   // extra edge, not a tree any more
        issue(tlca_pkg::CMD_ADD, lbl[$urandom_range(0, i)], lbl[$urandom_range(0, i)]);
    end
    issue(tlca_pkg::CMD_BUILD, NW'($urandom), NW'($urandom));
    for (int q = 0; q < 30; q++) begin
      a = lbl[$urandom_range(0, sz - 1)];
      b = lbl[$urandom_range(0, sz - 1)];
      case ($urandom_range(19))
        0: a = NW'($urandom);
        1: b = NW'($urandom);
        2: issue(tlca_pkg::CMD_ADD, lbl[$urandom_range(0, sz - 1)],
                 NW'($urandom_range(1, nc)));
        default: ;
      endcase
      if (q == 25 && $urandom_range(3) == 0) issue(tlca_pkg::CMD_CLEAR, a, b);
      issue(tlca_pkg::CMD_QUERY, a, b);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: defaults are node_count 1, root 1
    issue(tlca_pkg::CMD_QUERY, 1, 1);
    issue(tlca_pkg::CMD_ADD, 0, 1);
    issue(tlca_pkg::CMD_ADD, 1, 2);
    issue(tlca_pkg::CMD_BUILD, 0, 0);
    issue(tlca_pkg::CMD_QUERY, 1, 1);
    issue(tlca_pkg::CMD_QUERY, 0, 1);
    issue(tlca_pkg::CMD_QUERY, 1, 1023);
    issue(tlca_pkg::CMD_CLEAR, 1023, 1023);
    issue(tlca_pkg::CMD_QUERY, 1, 1);

    set_regs(1023, 1023);
    issue(tlca_pkg::CMD_ADD, 1023, 5);
    issue(tlca_pkg::CMD_ADD, 5, 1023);
    issue(tlca_pkg::CMD_ADD, 5, 682);
    issue(tlca_pkg::CMD_ADD, 682, 341);
    issue(tlca_pkg::CMD_ADD, 1023, 1);
    issue(tlca_pkg::CMD_ADD, 1, 682);        // second path to 682: first visit wins
    issue(tlca_pkg::CMD_BUILD, 0, 0);
    issue(tlca_pkg::CMD_QUERY, 341, 1);
    issue(tlca_pkg::CMD_QUERY, 1023, 1023);
    issue(tlca_pkg::CMD_QUERY, 341, 5);
    issue(tlca_pkg::CMD_QUERY, 7, 341);      // unreached node, no common ancestor
    issue(tlca_pkg::CMD_ADD, 341, 7);        // not visible until the next build
    issue(tlca_pkg::CMD_QUERY, 7, 341);

    set_regs(600, 0);
    issue(tlca_pkg::CMD_BUILD, 0, 0);
    issue(tlca_pkg::CMD_QUERY, 5, 5);
    set_regs(600, 5);              // 1023 is now a stale neighbor
    issue(tlca_pkg::CMD_BUILD, 0, 0);
    issue(tlca_pkg::CMD_QUERY, 341, 5);

    // repeated entries from one source
    set_regs(3, 1);
    issue(tlca_pkg::CMD_CLEAR, 0, 0);
    for (int i = 0; i < 8; i++) issue(tlca_pkg::CMD_ADD, 1, NW'($urandom_range(1, 3)));
    issue(tlca_pkg::CMD_BUILD, 0, 0);
    issue(tlca_pkg::CMD_QUERY, NW'($urandom_range(1, 3)), NW'($urandom_range(1, 3)));
    issue(tlca_pkg::CMD_CLEAR, 0, 0);

    for (int p = 0; p < 8; p++) random_phase(p);

    @(negedge clk);
    start <= 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
